// File: design/sbp_first_derivative_line_unit_assert.svh
// assertion macros for the sbp first-derivative line unit
// used by the modules that check their own control logic
`ifndef SBP_FIRST_DERIVATIVE_LINE_UNIT_ASSERT_SVH
`define SBP_FIRST_DERIVATIVE_LINE_UNIT_ASSERT_SVH

// plain property checked on every clock outside reset
`define SBP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define SBP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/sbp_pkg.sv
// shared types, constants and coefficient table for the sbp derivative unit
// no dependencies
`timescale 1ns / 1ps
package sbp_pkg;

   localparam int WindowDepth = 9;
   localparam int SampleBits  = 24;
   localparam int CoefBits    = 24;
   localparam int ProdBits    = SampleBits + CoefBits;
   localparam int SumBits     = ProdBits + 4;
   localparam int FracBits    = 22;
   localparam int DerivBits   = 27;
   localparam int IndexBits   = 12;
   localparam int LenBits     = 13;
   localparam int OrderBits   = 3;
   localparam int CsrIdxBits  = 2;

   localparam logic [CsrIdxBits-1:0] CSR_ORDER  = 2'd0;
   localparam logic [CsrIdxBits-1:0] CSR_LENGTH = 2'd1;

   typedef enum logic [1:0] {
      KIND_LEFT,
      KIND_INTERIOR,
      KIND_RIGHT
   } job_kind_type;

   // one derivative point handed from the sequencer to the tap row
   typedef struct packed {
      logic                 valid;
      job_kind_type         kind;
      logic [2:0]           row;
      logic [OrderBits-1:0] order;
      logic [IndexBits-1:0] idx;
      logic                 last;
   } job_type;

   // [p-2][row][tap], row 0 interior, rows 1.. left closure, signed q2.22
   localparam logic signed [CoefBits-1:0] COEF_TAB [0:2][0:6][0:8] = '{
      '{
         '{-24'sd2097152, 24'sd0, 24'sd2097152, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
           24'sd0, 24'sd0},
         '{-24'sd4194304, 24'sd4194304, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
           24'sd0, 24'sd0},
         '{-24'sd2097152, 24'sd0, 24'sd2097152, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
           24'sd0, 24'sd0},
         '{9{24'sd0}}, '{9{24'sd0}}, '{9{24'sd0}}, '{9{24'sd0}}
      },
      '{
         '{24'sd349525, -24'sd2796203, 24'sd0, 24'sd2796203, -24'sd349525,
           24'sd0, 24'sd0, 24'sd0, 24'sd0},
         '{-24'sd5921370, 24'sd7278351, -24'sd986895, -24'sd370086, 24'sd0,
           24'sd0, 24'sd0, 24'sd0, 24'sd0},
         '{-24'sd2097152, 24'sd0, 24'sd2097152, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
           24'sd0, 24'sd0},
         '{24'sd390168, -24'sd2877488, 24'sd0, 24'sd2877488, -24'sd390168,
           24'sd0, 24'sd0, 24'sd0, 24'sd0},
         '{24'sd128397, 24'sd0, -24'sd2525142, 24'sd0, 24'sd2739137,
           -24'sd342392, 24'sd0, 24'sd0, 24'sd0},
         '{9{24'sd0}}, '{9{24'sd0}}
      },
      '{
         '{-24'sd69905, 24'sd629146, -24'sd3145728, 24'sd0, 24'sd3145728,
           -24'sd629146, 24'sd69905, 24'sd0, 24'sd0},
         '{-24'sd6637627, 24'sd8375189, 24'sd20128, -24'sd2809621, 24'sd1051931,
           24'sd0, 24'sd0, 24'sd0, 24'sd0},
         '{-24'sd1903154, 24'sd0, 24'sd856225, 24'sd1782803, -24'sd812814,
           24'sd76940, 24'sd0, 24'sd0, 24'sd0},
         '{-24'sd10134, -24'sd1897055, 24'sd0, 24'sd997907, 24'sd1448770,
           -24'sd539489, 24'sd0, 24'sd0, 24'sd0},
         '{24'sd715590, -24'sd1998210, -24'sd504819, 24'sd0, 24'sd1791391,
           -24'sd60304, 24'sd56352, 24'sd0, 24'sd0},
         '{-24'sd364550, 24'sd1239601, -24'sd997237, -24'sd2437492, 24'sd0,
           24'sd3173088, -24'sd690087, 24'sd76676, 24'sd0},
         '{24'sd0, -24'sd105510, 24'sd333909, 24'sd73782, -24'sd2853179, 24'sd0,
           24'sd3102565, -24'sd620513, 24'sd68946}
      }
   };

   // coefficient that multiplies window slot k (0 newest) for one job
   function automatic logic signed [CoefBits-1:0] tap_coef(
      input logic [OrderBits-1:0] p,
      input job_kind_type         kind,
      input logic [2:0]           row,
      input logic [3:0]           k
   );
      logic [1:0] pi;
      logic [3:0] w;
      logic [3:0] span;
      logic [3:0] tap;
      logic [2:0] r;
      logic       use_it;
      pi     = p[1:0] - 2'd2;
      w      = 4'(3 * (p - 3'd1));
      span   = 4'(2 * p - 3'd2);
      tap    = 4'd0;
      r      = row;
      use_it = 1'b0;
      unique case (kind)
         KIND_LEFT: begin
            use_it = (k < w);
            tap    = w - 4'd1 - k;
         end
         KIND_INTERIOR: begin
            use_it = (k <= span);
            tap    = span - k;
            r      = 3'd0;
         end
         KIND_RIGHT: begin
            use_it = (k < w);
            tap    = k;
         end
         default: use_it = 1'b0;
      endcase
      if (use_it && tap <= 4'd8 && r <= 3'd6 && pi <= 2'd2) begin
         return COEF_TAB[pi][r][tap];
      end
      return '0;
   endfunction

endpackage

// File: design/sbp_tap_cell.sv
// one window cell: holds a sample, passes it on, multiplies by its coefficient
// depends on sbp_pkg
`timescale 1ns / 1ps
module sbp_tap_cell import sbp_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  logic                        capture_en,
   input  logic signed [SampleBits-1:0] sample_in,
   input  logic signed [CoefBits-1:0]  coef,
   output logic signed [SampleBits-1:0] sample_out,
   output logic signed [ProdBits-1:0]  product
);

   logic signed [SampleBits-1:0] sample_ff;
   logic signed [ProdBits-1:0]   prod_ff;

   // sample moves one cell older on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift_en) begin
         sample_ff <= sample_in;
      end
   end

   // product of the held sample and the coefficient of the issued point
   always_ff @(posedge clock) begin
      if (capture_en) begin
         prod_ff <= sample_ff * coef;
      end
   end

   assign sample_out = sample_ff;
   assign product    = prod_ff;

endmodule

// File: design/sbp_job_seq.sv
// point sequencer: line counters, config registers, issue of derivative points
// depends on sbp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "sbp_first_derivative_line_unit_assert.svh"
module sbp_job_seq import sbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CsrIdxBits-1:0] csr_index,
   input  logic [LenBits-1:0]    csr_wdata,
   input  logic                  req_valid,
   input  logic                  advance,
   output logic                  req_ready,
   output logic                  accept,
   output job_type               job
);

   logic [OrderBits-1:0] order_ff;
   logic [LenBits-1:0]   length_ff;
   logic [LenBits-1:0]   count_ff, count_in;
   logic [2:0]           jobs_ff, jobs_in;
   job_kind_type         kind_ff, kind_in;
   logic [2:0]           row_ff, row_in;
   logic [IndexBits-1:0] idx_ff, idx_in;

   logic [OrderBits-1:0] p;
   logic [LenBits-1:0]   n;
   logic [2:0]           nl;
   logic [3:0]           w;
   logic                 issue;
   logic                 interior;

   // clamp the configured order and length
   always_comb begin
      p = order_ff;
      if (p < 3'd2) p = 3'd2;
      if (p > 3'd4) p = 3'd4;
      n = length_ff;
      if (n < 13'd12)   n = 13'd12;
      if (n > 13'd4096) n = 13'd4096;
      nl = 3'(2 * (p - 3'd1));
      w  = 4'(3 * (p - 3'd1));
   end

   assign issue     = advance && (jobs_ff != 3'd0);
   assign req_ready = advance && (jobs_ff <= 3'd1);
   assign accept    = req_valid && req_ready;
   assign interior  = (count_ff >= LenBits'(w)) &&
                      ((14'(count_ff) + 14'(nl)) < (14'(n) + 14'(p) - 14'd1));

   // next job set and line counter
   always_comb begin
      count_in = count_ff;
      jobs_in  = jobs_ff;
      kind_in  = kind_ff;
      row_in   = row_ff;
      idx_in   = idx_ff;
      if (issue) begin
         jobs_in = jobs_ff - 3'd1;
         idx_in  = idx_ff + 1'b1;
         row_in  = (kind_ff == KIND_RIGHT) ? row_ff - 3'd1 : row_ff + 3'd1;
      end
      if (accept) begin
         count_in = count_ff + 1'b1;
         priority if (count_ff == LenBits'(w) - 1'b1) begin
            jobs_in = nl;
            kind_in = KIND_LEFT;
            row_in  = 3'd1;
            idx_in  = '0;
         end else if (count_ff >= n - 1'b1) begin
            jobs_in  = nl;
            kind_in  = KIND_RIGHT;
            row_in   = nl;
            idx_in   = IndexBits'(n - LenBits'(nl));
            count_in = '0;
         end else if (interior) begin
            jobs_in = 3'd1;
            kind_in = KIND_INTERIOR;
            idx_in  = IndexBits'(count_ff - LenBits'(p) + 1'b1);
         end
      end
      if (csr_we && (csr_index == CSR_ORDER || csr_index == CSR_LENGTH)) begin
         count_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff  <= 3'd4;
         length_ff <= 13'd64;
         count_ff  <= '0;
         jobs_ff   <= '0;
         kind_ff   <= KIND_LEFT;
         row_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         count_ff <= count_in;
         jobs_ff  <= jobs_in;
         kind_ff  <= kind_in;
         row_ff   <= row_in;
         idx_ff   <= idx_in;
         if (csr_we && csr_index == CSR_ORDER) begin
            order_ff <= csr_wdata[OrderBits-1:0];
         end
         if (csr_we && csr_index == CSR_LENGTH) begin
            length_ff <= csr_wdata;
         end
      end
   end

   // point handed to the tap row this cycle
   always_comb begin
      job.valid = issue;
      job.kind  = kind_ff;
      job.row   = row_ff;
      job.order = p;
      job.idx   = idx_ff;
      job.last  = (LenBits'(idx_ff) == n - 1'b1);
   end

   `SBP_ASSERT_IMP(a_accept_free, clock, reset, accept, jobs_ff == 3'd0 || issue, "item taken over pending points")
   `SBP_ASSERT(a_jobs_bound, clock, reset, jobs_ff <= 3'd6, "more than six pending points")
   `SBP_ASSERT_IMP(a_closure_row, clock, reset, issue && kind_ff != KIND_INTERIOR, row_ff != 3'd0 && row_ff <= nl, "closure row out of range")

endmodule

// File: design/sbp_first_derivative_line_unit.sv
// top level of the sbp first-derivative line unit: tap cell chain, sum, round
// depends on sbp_pkg, sbp_tap_cell and sbp_job_seq
`timescale 1ns / 1ps
// Usage:
// Samples of one line enter on the req channel (req_valid/req_ready) in index
// order. Derivative points leave on the rsp channel (rsp_valid/rsp_ready) with
// their point index and a flag on the last point of the line.
// csr_we writes order (index 0) or line_length (index 1); either write restarts
// the line and keeps the sample window.
// Throughput while rsp is not stalled: one sample per cycle in the line
// interior, one point per cycle. On sample 3(p-1)-1 and on the final sample a
// burst of 2(p-1) points is issued one per cycle unless stalled; the req channel
// holds until at most one of them is pending. After its last sample is taken, a
// point passes issue, tap cell products, adder tree, round and saturate.
// The whole pipeline stalls while rsp_valid is high and rsp_ready is low; the
// output register decouples the two sides otherwise.
// Reset: order 4, line length 64, window cleared, line counters at zero,
// no point pending.
module sbp_first_derivative_line_unit import sbp_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [CsrIdxBits-1:0]        csr_index,
   input  logic [LenBits-1:0]           csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SampleBits-1:0] req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DerivBits-1:0]  rsp_derivative,
   output logic [IndexBits-1:0]         rsp_point_index,
   output logic                         rsp_last_of_line
);

   logic    advance;
   logic    accept;
   job_type job;

   logic signed [SampleBits-1:0] chain [0:WindowDepth];
   logic signed [ProdBits-1:0]   prod  [0:WindowDepth-1];

   logic                 s1_valid_ff, s1_last_ff, s1_neg_ff;
   logic [IndexBits-1:0] s1_idx_ff;
   logic                 s2_valid_ff, s2_last_ff;
   logic [IndexBits-1:0] s2_idx_ff;
   logic signed [SumBits-1:0] s2_sum_ff, sum_in;
   logic signed [SumBits:0]   rounded;
   logic signed [SumBits-FracBits:0] quot;
   logic signed [DerivBits-1:0] deriv_in;

   logic                        rsp_valid_ff;
   logic signed [DerivBits-1:0] rsp_deriv_ff;
   logic [IndexBits-1:0]        rsp_idx_ff;
   logic                        rsp_last_ff;

   assign advance = !rsp_valid_ff || rsp_ready;

   sbp_job_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .advance   (advance),
      .req_ready (req_ready),
      .accept    (accept),
      .job       (job)
   );

   // chain of window cells, newest at cell 0
   assign chain[0] = req_sample;
   for (genvar k = 0; k < WindowDepth; k++) begin : g_cell
      sbp_tap_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .capture_en (advance),
         .sample_in  (chain[k]),
         .coef       (tap_coef(job.order, job.kind, job.row, 4'(k))),
         .sample_out (chain[k+1]),
         .product    (prod[k])
      );
   end

   // sideband alongside the products
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= job.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_idx_ff  <= job.idx;
         s1_last_ff <= job.last;
         s1_neg_ff  <= (job.kind == KIND_RIGHT);
      end
   end

   // sum of the tap products, negated for the right closure
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < WindowDepth; k++) begin
         sum_in = sum_in + SumBits'(prod[k]);
      end
      if (s1_neg_ff) begin
         sum_in = -sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sum_ff  <= sum_in;
         s2_idx_ff  <= s1_idx_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // round half up at the binary point, then saturate
   always_comb begin
      rounded = (SumBits+1)'(s2_sum_ff) + (SumBits+1)'(1 << (FracBits - 1));
      quot    = rounded[SumBits:FracBits];
      if (quot > (SumBits-FracBits+1)'((1 << (DerivBits - 1)) - 1)) begin
         deriv_in = {1'b0, {(DerivBits-1){1'b1}}};
      end else if (quot < -(SumBits-FracBits+1)'(1 << (DerivBits - 1))) begin
         deriv_in = {1'b1, {(DerivBits-1){1'b0}}};
      end else begin
         deriv_in = quot[DerivBits-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_deriv_ff <= deriv_in;
         rsp_idx_ff   <= s2_idx_ff;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_derivative   = rsp_deriv_ff;
   assign rsp_point_index  = rsp_idx_ff;
   assign rsp_last_of_line = rsp_last_ff;

endmodule
